// File: rtl/bkrd_pkg.sv
// Shared types and constants for the boot keyboard report differ.
package bkrd_pkg;

  localparam int unsigned NumSlots  = 6;
  localparam int unsigned NumEvents = 2 * NumSlots + 1;

  typedef logic [7:0] code_t;

  localparam code_t CapsLockCode = 8'h39;
  localparam code_t RolloverCode = 8'h01;

  typedef enum logic [1:0] {
    EvModifier = 2'd0,
    EvDown     = 2'd1,
    EvUp       = 2'd2
  } evt_kind_e;

  // What one slot lane finds.
  typedef struct packed {
    logic down;        // current code is new (or rollover)
    logic up;          // held code is gone (or rollover), not caps lock
    logic caps_press;  // down event on the caps lock key
  } lane_flags_t;

  // One report worth of pending events, bit 0 first.
  typedef struct packed {
    logic [NumEvents-1:0]             mask;
    evt_kind_e [NumEvents-1:0]        kind;
    logic [NumEvents-1:0][7:0]        code;
    code_t                            cur_mods;
    code_t                            prev_mods;
  } report_t;

endpackage

// File: rtl/bkrd_if.sv
// Beat channels: keyboard report in, change event out.
interface bkrd_rpt_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] reserved_byte;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;

  modport source (
    output valid, modifiers, reserved_byte, slot_zero, slot_one, slot_two,
           slot_three, slot_four, slot_five,
    input  ready
  );
  modport sink (
    input  valid, modifiers, reserved_byte, slot_zero, slot_one, slot_two,
           slot_three, slot_four, slot_five,
    output ready
  );
endinterface

interface bkrd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] current_modifiers;
  logic [7:0] earlier_modifiers;
  logic [7:0] usage_code;
  logic       last_event;

  modport source (
    output valid, event_kind, current_modifiers, earlier_modifiers, usage_code,
           last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, current_modifiers, earlier_modifiers, usage_code,
           last_event,
    output ready
  );
endinterface

// File: rtl/bkrd_lane.sv
// One slot lane: match the slot's current and held codes against the other report.
module bkrd_lane (
  input  bkrd_pkg::code_t                          cur_code_i,
  input  bkrd_pkg::code_t                          held_code_i,
  input  bkrd_pkg::code_t [bkrd_pkg::NumSlots-1:0] cur_all_i,
  input  bkrd_pkg::code_t [bkrd_pkg::NumSlots-1:0] held_all_i,
  output bkrd_pkg::lane_flags_t                    flags_o
);
  import bkrd_pkg::*;

  logic cur_hit;
  logic held_hit;

  always_comb begin
    cur_hit  = 1'b0;
    held_hit = 1'b0;
    for (int j = 0; j < NumSlots; j++) begin
      if (cur_code_i == held_all_i[j]) cur_hit = 1'b1;
      if (held_code_i == cur_all_i[j]) held_hit = 1'b1;
    end
  end

  // rollover never counts as a match; a released caps lock is silent
  assign flags_o.down       = !(cur_hit && (cur_code_i != RolloverCode));
  assign flags_o.up         = !(held_hit && (held_code_i != RolloverCode)) &&
                              (held_code_i != CapsLockCode);
  assign flags_o.caps_press = flags_o.down && (cur_code_i == CapsLockCode);

endmodule

// File: rtl/bkrd_merge.sv
// Merge lane results into an ordered event set and track caps lock.
module bkrd_merge (
  input  bkrd_pkg::lane_flags_t [bkrd_pkg::NumSlots-1:0] flags_i,
  input  bkrd_pkg::code_t [bkrd_pkg::NumSlots-1:0]       cur_slots_i,
  input  bkrd_pkg::code_t [bkrd_pkg::NumSlots-1:0]       held_slots_i,
  input  bkrd_pkg::code_t                                cur_mods_i,
  input  bkrd_pkg::code_t                                held_mods_i,
  input  logic                                           caps_i,
  output logic                                           caps_o,
  output bkrd_pkg::report_t                              rpt_o
);
  import bkrd_pkg::*;

  logic caps;

  always_comb begin
    caps = caps_i;
    rpt_o.mask[0]   = (cur_mods_i != held_mods_i);
    rpt_o.kind[0]   = EvModifier;
    rpt_o.code[0]   = '0;
    rpt_o.cur_mods  = cur_mods_i;
    rpt_o.prev_mods = held_mods_i;
    for (int i = 0; i < NumSlots; i++) begin
      // caps flag toggles in slot order, each press sees the new value
      caps = caps ^ flags_i[i].caps_press;
      rpt_o.mask[2*i+1] = flags_i[i].down;
      rpt_o.code[2*i+1] = cur_slots_i[i];
      if (flags_i[i].caps_press) begin
        rpt_o.kind[2*i+1] = caps ? EvDown : EvUp;
      end else begin
        rpt_o.kind[2*i+1] = EvDown;
      end
      rpt_o.mask[2*i+2] = flags_i[i].up;
      rpt_o.code[2*i+2] = held_slots_i[i];
      rpt_o.kind[2*i+2] = EvUp;
    end
    caps_o = caps;
  end

endmodule

// File: rtl/bkrd_emit.sv
// Event buffer for one report and the output register, one event per beat.
module bkrd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bkrd_pkg::report_t  rpt_i,
  output logic               in_ready_o,
  bkrd_evt_if.source         evt_o
);
  import bkrd_pkg::*;

  logic                  buf_valid_q, buf_valid_d;
  logic [NumEvents-1:0]  mask_q, mask_d;
  report_t               rpt_q;

  logic                  out_valid_q, out_valid_d;
  evt_kind_e             kind_q;
  code_t                 cur_mods_q, prev_mods_q, code_q;
  logic                  last_q;

  logic                  out_free;
  logic                  pop;
  logic [NumEvents-1:0]  onehot;
  logic [NumEvents-1:0]  rest;
  logic                  last;
  evt_kind_e             sel_kind;
  code_t                 sel_code;

  assign out_free = !out_valid_q || evt_o.ready;
  assign pop      = buf_valid_q && out_free;
  assign onehot   = mask_q & (~mask_q + {{(NumEvents-1){1'b0}}, 1'b1});
  assign rest     = mask_q & ~onehot;
  assign last     = (rest == '0);

  assign in_ready_o = !buf_valid_q || (pop && last);

  always_comb begin
    sel_kind = EvModifier;
    sel_code = '0;
    for (int j = 0; j < NumEvents; j++) begin
      if (onehot[j]) begin
        sel_kind = rpt_q.kind[j];
        sel_code = rpt_q.code[j];
      end
    end
  end

  always_comb begin
    buf_valid_d = buf_valid_q;
    mask_d      = mask_q;
    if (load_i) begin
      buf_valid_d = (rpt_i.mask != '0);
      mask_d      = rpt_i.mask;
    end else if (pop) begin
      buf_valid_d = !last;
      mask_d      = rest;
    end
    out_valid_d = pop ? 1'b1 : (evt_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) rpt_q <= rpt_i;
    if (pop) begin
      kind_q      <= sel_kind;
      code_q      <= sel_code;
      cur_mods_q  <= rpt_q.cur_mods;
      prev_mods_q <= onehot[0] ? rpt_q.prev_mods : '0;
      last_q      <= last;
    end
  end

  assign evt_o.valid             = out_valid_q;
  assign evt_o.event_kind        = kind_q;
  assign evt_o.current_modifiers = cur_mods_q;
  assign evt_o.earlier_modifiers = prev_mods_q;
  assign evt_o.usage_code        = code_q;
  assign evt_o.last_event        = last_q;

  a_buf_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (mask_q != '0))
    else $error("event buffer valid with empty mask");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!buf_valid_q || (pop && last)))
    else $error("report loaded over pending events");

  a_pop_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> $onehot(onehot))
    else $error("event select not one-hot");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q == EvModifier || kind_q == EvDown || kind_q == EvUp))
    else $error("illegal event kind");

endmodule

// File: rtl/boot_keyboard_report_differ.sv
// Boot keyboard report differ: top level, held report state and caps lock flag.
//
// Takes one 8-byte boot keyboard report per input beat and emits its change
// events on the output channel, one event per beat: a modifier change first
// (if the modifier byte moved), then per key slot in order a key down and a
// key up. A rollover code (1) never matches, the caps lock key (0x39) toggles
// an internal flag and reports down or up by its new value, and its release
// is silent. last_event marks the final event of a report; a report that
// changes nothing produces no beat. Six slot lanes compare every slot against
// the other report in parallel in the accept cycle; the held report updates
// right then, so the next report can be compared at once. A report's events,
// up to 13, wait in the event buffer and leave one event per cycle through
// the output register while the sink is ready; the next report is taken in
// the cycle its predecessor's last event moves to the output register.
module boot_keyboard_report_differ (
  input  logic      clk_i,
  input  logic      rst_ni,
  bkrd_rpt_if.sink  rpt_i,
  bkrd_evt_if.source evt_o
);
  import bkrd_pkg::*;

  code_t                           held_mods_q;
  code_t [NumSlots-1:0]            held_slots_q;
  logic                            caps_q, caps_d;

  code_t [NumSlots-1:0]            cur_slots;
  lane_flags_t [NumSlots-1:0]      flags;
  report_t                         rpt;
  logic                            in_ready;
  logic                            accept;

  assign cur_slots[0] = rpt_i.slot_zero;
  assign cur_slots[1] = rpt_i.slot_one;
  assign cur_slots[2] = rpt_i.slot_two;
  assign cur_slots[3] = rpt_i.slot_three;
  assign cur_slots[4] = rpt_i.slot_four;
  assign cur_slots[5] = rpt_i.slot_five;

  assign rpt_i.ready = in_ready;
  assign accept      = rpt_i.valid && in_ready;

  // per-slot comparison lanes
  for (genvar i = 0; i < NumSlots; i++) begin : g_lane
    bkrd_lane u_lane (
      .cur_code_i  (cur_slots[i]),
      .held_code_i (held_slots_q[i]),
      .cur_all_i   (cur_slots),
      .held_all_i  (held_slots_q),
      .flags_o     (flags[i])
    );
  end

  bkrd_merge u_merge (
    .flags_i      (flags),
    .cur_slots_i  (cur_slots),
    .held_slots_i (held_slots_q),
    .cur_mods_i   (rpt_i.modifiers),
    .held_mods_i  (held_mods_q),
    .caps_i       (caps_q),
    .caps_o       (caps_d),
    .rpt_o        (rpt)
  );

  bkrd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .rpt_i      (rpt),
    .in_ready_o (in_ready),
    .evt_o      (evt_o)
  );

  // held report replaces on every accepted beat; reserved byte is not kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mods_q  <= '0;
      held_slots_q <= '0;
      caps_q       <= 1'b0;
    end else if (accept) begin
      held_mods_q  <= rpt_i.modifiers;
      held_slots_q <= cur_slots;
      caps_q       <= caps_d;
    end
  end

endmodule
